// ----- sv/spp_pkg.sv -----
// Shared types, operation codes and shuffle patterns for the packed permute unit.
package spp_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    OP_COPY_HALF     = 5'd0,
    OP_COPY_LO_DW    = 5'd1,
    OP_COPY_HI_DW    = 5'd2,
    OP_EXCH_CENT_HW  = 5'd3,
    OP_EXCH_CENT_WD  = 5'd4,
    OP_EXCH_EVEN_HW  = 5'd5,
    OP_EXCH_EVEN_WD  = 5'd6,
    OP_ILV_LO_BYTE   = 5'd7,
    OP_ILV_LO_HW     = 5'd8,
    OP_ILV_LO_WD     = 5'd9,
    OP_ILV_HI_BYTE   = 5'd10,
    OP_ILV_HI_HW     = 5'd11,
    OP_ILV_HI_WD     = 5'd12,
    OP_ILV_EVEN_HW   = 5'd13,
    OP_ILV_HW        = 5'd14,
    OP_PACK_BYTE     = 5'd15,
    OP_PACK_HW       = 5'd16,
    OP_PACK_WD       = 5'd17,
    OP_REV_HW        = 5'd18,
    OP_ROT3_WD       = 5'd19
  } op_t;

  // Four-element shuffle patterns: result element k takes source element P[k]
  localparam logic [1:0] P_CENT [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
  localparam logic [1:0] P_EVEN [4] = '{2'd2, 2'd1, 2'd0, 2'd3};
  localparam logic [1:0] P_REV  [4] = '{2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic [1:0] P_ROT  [4] = '{2'd1, 2'd2, 2'd0, 2'd3};

  // Request payload
  typedef struct packed {
    logic [4:0]  req_type;
    logic [63:0] rs_low;
    logic [63:0] rs_high;
    logic [63:0] rt_low;
    logic [63:0] rt_high;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [63:0] rd_low;
    logic [63:0] rd_high;
  } rsp_t;

endpackage

// ----- sv/simd_packed_permute_unit_top.sv -----
// Top level of the packed permute unit: input register, permute network, result register.
// A request transfer lands in an input register; from there the permute network
// reorders the operands and the result is captured in the output register when the
// result side can take it, and one item can be accepted every cycle while req_stall
// is low. Throughput is set by the two-entry register pipeline: req_stall
// rises only when both registers hold items and the result side is stalled. The unit
// keeps no state between items; undefined operation codes return zero.
module simd_packed_permute_unit_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spp_pkg::rsp_t rsp
);

  logic          in_valid;
  spp_pkg::req_t in_req;
  spp_pkg::rsp_t perm_rsp;
  logic          out_load_ok;
  logic          in_load_ok;

  // Stage enables: each register moves when its downstream can take it
  assign out_load_ok = !rsp_valid || !rsp_stall;
  assign in_load_ok  = !in_valid || out_load_ok;
  assign req_stall   = !in_load_ok;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load_ok) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load_ok && req_valid) begin
      in_req <= req;
    end
  end

  spp_permute u_permute (
    .req (in_req),
    .rsp (perm_rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load_ok) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_ok && in_valid) begin
      rsp <= perm_rsp;
    end
  end

endmodule

// ----- sv/spp_permute.sv -----
// Combinational byte/halfword/word reordering network for one request.
module spp_permute (
  input  spp_pkg::req_t req,
  output spp_pkg::rsp_t rsp
);

  logic [127:0] s;
  logic [127:0] t;
  logic [127:0] r;

  assign s = {req.rs_high, req.rs_low};
  assign t = {req.rt_high, req.rt_low};

  // Element select per operation; every arm defines all 128 bits
  always_comb begin
    r = '0;
    case (spp_pkg::op_t'(req.req_type))
      spp_pkg::OP_COPY_HALF: begin
        for (int k = 0; k < 4; k++) begin
          r[16*k +: 16]     = t[15:0];
          r[16*(4+k) +: 16] = t[79:64];
        end
      end
      spp_pkg::OP_COPY_LO_DW: r = {s[63:0], t[63:0]};
      spp_pkg::OP_COPY_HI_DW: r = {t[127:64], s[127:64]};
      spp_pkg::OP_EXCH_CENT_HW: begin
        for (int g = 0; g < 2; g++)
          for (int k = 0; k < 4; k++)
            r[16*(4*g+k) +: 16] = t[16*(4*g+int'(spp_pkg::P_CENT[k])) +: 16];
      end
      spp_pkg::OP_EXCH_CENT_WD: begin
        for (int k = 0; k < 4; k++)
          r[32*k +: 32] = t[32*int'(spp_pkg::P_CENT[k]) +: 32];
      end
      spp_pkg::OP_EXCH_EVEN_HW: begin
        for (int g = 0; g < 2; g++)
          for (int k = 0; k < 4; k++)
            r[16*(4*g+k) +: 16] = t[16*(4*g+int'(spp_pkg::P_EVEN[k])) +: 16];
      end
      spp_pkg::OP_EXCH_EVEN_WD: begin
        for (int k = 0; k < 4; k++)
          r[32*k +: 32] = t[32*int'(spp_pkg::P_EVEN[k]) +: 32];
      end
      spp_pkg::OP_ILV_LO_BYTE: begin
        for (int i = 0; i < 8; i++) begin
          r[8*(2*i) +: 8]   = t[8*i +: 8];
          r[8*(2*i+1) +: 8] = s[8*i +: 8];
        end
      end
      spp_pkg::OP_ILV_LO_HW: begin
        for (int i = 0; i < 4; i++) begin
          r[16*(2*i) +: 16]   = t[16*i +: 16];
          r[16*(2*i+1) +: 16] = s[16*i +: 16];
        end
      end
      spp_pkg::OP_ILV_LO_WD: begin
        for (int i = 0; i < 2; i++) begin
          r[32*(2*i) +: 32]   = t[32*i +: 32];
          r[32*(2*i+1) +: 32] = s[32*i +: 32];
        end
      end
      spp_pkg::OP_ILV_HI_BYTE: begin
        for (int i = 0; i < 8; i++) begin
          r[8*(2*i) +: 8]   = t[8*(8+i) +: 8];
          r[8*(2*i+1) +: 8] = s[8*(8+i) +: 8];
        end
      end
      spp_pkg::OP_ILV_HI_HW: begin
        for (int i = 0; i < 4; i++) begin
          r[16*(2*i) +: 16]   = t[16*(4+i) +: 16];
          r[16*(2*i+1) +: 16] = s[16*(4+i) +: 16];
        end
      end
      spp_pkg::OP_ILV_HI_WD: begin
        for (int i = 0; i < 2; i++) begin
          r[32*(2*i) +: 32]   = t[32*(2+i) +: 32];
          r[32*(2*i+1) +: 32] = s[32*(2+i) +: 32];
        end
      end
      spp_pkg::OP_ILV_EVEN_HW: begin
        for (int i = 0; i < 4; i++) begin
          r[16*(2*i) +: 16]   = t[16*(2*i) +: 16];
          r[16*(2*i+1) +: 16] = s[16*(2*i) +: 16];
        end
      end
      spp_pkg::OP_ILV_HW: begin
        for (int k = 0; k < 4; k++) begin
          r[16*(2*k) +: 16]   = t[16*k +: 16];
          r[16*(2*k+1) +: 16] = s[16*(4+k) +: 16];
        end
      end
      spp_pkg::OP_PACK_BYTE: begin
        for (int i = 0; i < 8; i++) begin
          r[8*i +: 8]     = t[8*(2*i) +: 8];
          r[8*(8+i) +: 8] = s[8*(2*i) +: 8];
        end
      end
      spp_pkg::OP_PACK_HW: begin
        for (int i = 0; i < 4; i++) begin
          r[16*i +: 16]     = t[16*(2*i) +: 16];
          r[16*(4+i) +: 16] = s[16*(2*i) +: 16];
        end
      end
      spp_pkg::OP_PACK_WD: begin
        for (int i = 0; i < 2; i++) begin
          r[32*i +: 32]     = t[32*(2*i) +: 32];
          r[32*(2+i) +: 32] = s[32*(2*i) +: 32];
        end
      end
      spp_pkg::OP_REV_HW: begin
        for (int g = 0; g < 2; g++)
          for (int k = 0; k < 4; k++)
            r[16*(4*g+k) +: 16] = t[16*(4*g+int'(spp_pkg::P_REV[k])) +: 16];
      end
      spp_pkg::OP_ROT3_WD: begin
        for (int k = 0; k < 4; k++)
          r[32*k +: 32] = t[32*int'(spp_pkg::P_ROT[k]) +: 32];
      end
      // Undefined codes give zero
      default: r = '0;
    endcase
  end

  assign rsp.rd_low  = r[63:0];
  assign rsp.rd_high = r[127:64];

endmodule
